>>> rtl/bounded_substring_search_core_defines.svh
// ----------------------------------------------------------------------------
// bounded substring search core assertion macros
// shared concurrent assertion forms, clocked on clk, off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SUBSTRING_SEARCH_CORE_DEFINES_SVH
`define BOUNDED_SUBSTRING_SEARCH_CORE_DEFINES_SVH

// same-cycle implication
`define BSS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_pkg
// shared widths, register codes and the result type of the substring search
// ----------------------------------------------------------------------------
package bss_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int POS_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [BYTE_W-1:0] TEXT_END_BYTE = 8'h00;
  localparam logic [POS_W-1:0]  POS_MAX       = 16'hFFFF;
  localparam logic [POS_W-1:0]  LIMIT_RESET   = 16'hFFFF;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEEDLE_LOW   = 2'd0,
    CFG_NEEDLE_HIGH  = 2'd1,
    CFG_NEEDLE_LEN   = 2'd2,
    CFG_SEARCH_LIMIT = 2'd3
  } cfg_reg_t;

  // one search result
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } res_t;

endpackage

>>> rtl/bounded_substring_search_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_substring_search_core
// streaming bounded substring search over haystack bytes, one byte a request
// ----------------------------------------------------------------------------
// Usage:
//   in_ channel: one haystack byte per request, in_end_of_text on the last
//   byte of a string. A byte of value zero ends the search of that string.
//   out_ channel: one request per string, match_found and match_position
//   (start index of the first match, zero when not found).
//   cfg_ channel: register writes (index 0/1 needle bytes, 2 needle length,
//   3 search limit); cfg_ready is always high, write only while idle.
// Timing:
//   one byte accepted per cycle while in_stall is low; each result is kept in
//   the output register driving out_, or the skid entry. A row of NEEDLE_MAX
//   compare cells updates the partial-match vector, which sets the rate.
// Reset and stall:
//   reset clears the string state, the needle and length to zero and the
//   limit to 65535. An output register plus one skid entry hold results;
//   in_stall rises only when both are full under out_stall.
// ----------------------------------------------------------------------------
`include "bounded_substring_search_core_defines.svh"

module bounded_substring_search_core
  import bss_pkg::*;
#(
  parameter int NEEDLE_MAX = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // haystack requests
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     in_text_byte,
  input  logic                  in_end_of_text,
  // result requests
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_match_found,
  output logic [POS_W-1:0]      out_match_position,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_DATA_W-1:0]   needle_low_r;
  logic [CFG_DATA_W-1:0]   needle_high_r;
  logic [LEN_W-1:0]        needle_len_r;
  logic [POS_W-1:0]        limit_r;
  logic [POS_W-1:0]        pos_r;
  logic [POS_W-1:0]        pos_nxt;
  logic                    given_r;
  logic                    given_nxt;
  logic [2*CFG_DATA_W-1:0] needle;
  logic [LEN_W-1:0]        len_eff;
  logic                    accept;
  logic                    clear;
  logic                    empty;
  logic                    term;
  logic                    advance;
  logic                    hit;
  logic                    res_push;
  res_t                    res;
  res_t                    out_res;
  logic                    buf_full;
  logic [NEEDLE_MAX-1:0]   cell_bit;
  logic [NEEDLE_MAX-1:0]   cell_tail;

  assign cfg_ready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_low_r  <= '0;
      needle_high_r <= '0;
      needle_len_r  <= '0;
      limit_r       <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_NEEDLE_LOW:   needle_low_r  <= cfg_data;
        CFG_NEEDLE_HIGH:  needle_high_r <= cfg_data;
        CFG_NEEDLE_LEN:   needle_len_r  <= cfg_data[LEN_W-1:0];
        CFG_SEARCH_LIMIT: limit_r       <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  assign needle  = {needle_high_r, needle_low_r};
  assign len_eff = (needle_len_r > LEN_W'(NEEDLE_MAX)) ? LEN_W'(NEEDLE_MAX) : needle_len_r;

  // request decode
  assign accept  = in_valid && !in_stall;
  assign clear   = accept && in_end_of_text;
  assign empty   = (len_eff == '0);
  assign term    = (in_text_byte == TEXT_END_BYTE) || (pos_r >= limit_r);
  assign advance = accept && !given_r && !empty && !term;

  // row of compare cells
  for (genvar i = 0; i < NEEDLE_MAX; i++) begin : g_cell
    logic prev_bit;
    if (i == 0) begin : g_head
      assign prev_bit = 1'b1;
    end else begin : g_link
      assign prev_bit = cell_bit[i-1];
    end
    bss_cell #(
      .INDEX (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .clear       (clear),
      .advance     (advance),
      .text_byte   (in_text_byte),
      .needle_byte (needle[i*BYTE_W +: BYTE_W]),
      .needle_len  (len_eff),
      .prev_bit    (prev_bit),
      .match_bit   (cell_bit[i]),
      .tail_hit    (cell_tail[i])
    );
  end

  assign hit = |cell_tail;

  // result of this request
  assign res_push     = accept && !given_r && (empty || term || hit || in_end_of_text);
  assign res.found    = empty || (!term && hit);
  assign res.position = (!empty && !term && hit) ?
                        (pos_r + POS_W'(1) - POS_W'(len_eff)) : '0;

  // string state next values
  always_comb begin
    pos_nxt   = pos_r;
    given_nxt = given_r;
    if (clear) begin
      pos_nxt   = '0;
      given_nxt = 1'b0;
    end else begin
      if (advance && (pos_r != POS_MAX)) begin
        pos_nxt = pos_r + POS_W'(1);
      end
      if (res_push) begin
        given_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      given_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      given_r <= given_nxt;
    end
  end

  // result buffer
  bss_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_res  (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign in_stall           = buf_full;
  assign out_match_found    = out_res.found;
  assign out_match_position = out_res.position;

  // checks
  `BSS_ASSERT_SAME(a_one_result, given_r, !res_push, "second result for one string")
  `BSS_ASSERT_NEXT(a_clear_state, clear, (pos_r == '0) && !given_r, "string state not cleared")
  `BSS_ASSERT_SAME(a_miss_pos_zero, res_push && !res.found, res.position == '0, "miss with position")
  `BSS_ASSERT_SAME(a_stall_full, in_stall, out_valid, "stall while output empty")
  `BSS_ASSERT_NEXT(a_hit_given, advance && hit && !in_end_of_text, given_r, "match not recorded")

endmodule

>>> rtl/bss_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_cell
// one needle position: compares the text byte and holds its partial-match bit
// ----------------------------------------------------------------------------
module bss_cell
  import bss_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clear,
  input  logic              advance,
  input  logic [BYTE_W-1:0] text_byte,
  input  logic [BYTE_W-1:0] needle_byte,
  input  logic [LEN_W-1:0]  needle_len,
  input  logic              prev_bit,
  output logic              match_bit,
  output logic              tail_hit
);

  logic match_bit_r;
  logic match_bit_nxt;
  logic in_use;

  // cell is part of the needle when its index is below the length
  assign in_use        = LEN_W'(INDEX) < needle_len;
  assign match_bit_nxt = prev_bit && in_use && (text_byte == needle_byte);

  // last needle position completes a match
  assign tail_hit = match_bit_nxt && (needle_len == LEN_W'(INDEX + 1));

  // partial-match bit, handed to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      match_bit_r <= 1'b0;
    end else if (advance) begin
      match_bit_r <= match_bit_nxt;
    end
  end

  assign match_bit = match_bit_r;

endmodule

>>> rtl/bss_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bss_out_buf
// output register with one skid entry, decouples the result channel stall
// ----------------------------------------------------------------------------
module bss_out_buf
  import bss_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_res,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_res
);

  logic out_valid_r;
  logic out_valid_nxt;
  logic skid_valid_r;
  logic skid_valid_nxt;
  res_t out_res_r;
  res_t out_res_nxt;
  res_t skid_res_r;
  res_t skid_res_nxt;
  logic pop;
  logic out_free;

  assign pop      = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || pop;

  // next state of both entries; no push arrives while the skid is full
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (out_free) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = push;
        out_res_nxt   = push_res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = push_res;
    end
  end

  // control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
